### hw/rtl/gcm_pkg.sv
// ----------------------------------------------------------------------------
// gcm_pkg: shared types and constants for the gradient color map
// Field widths, register indexes, the reset gradient and the control record
// carried down the pipeline next to the arithmetic.
// ----------------------------------------------------------------------------
package gcm_pkg;

  // Field widths
  localparam int POS_W      = 17;                // Q16 position / level
  localparam int CHAN_W     = 8;                 // one color channel
  localparam int COLOR_W    = 3 * CHAN_W;        // packed red, green, blue
  localparam int STOP_W     = POS_W + COLOR_W;   // one stop word
  localparam int COUNT_W    = 3;                 // stop count register
  localparam int CFG_ADDR_W = 3;                 // register index
  localparam int NUM_CHAN   = 3;

  // Divider sizing: quotient always fits in one channel
  localparam int DIV_STEPS  = CHAN_W;
  localparam int PROD_W     = CHAN_W + POS_W;
  localparam int SUM_W      = CHAN_W + 2;

  // Register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_STOP_COUNT = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_STOP_BASE  = 3'd1;

  localparam logic [COUNT_W-1:0] STOP_COUNT_RST = 3'd5;

  // Bit positions inside a stop word
  localparam int POS_LSB = COLOR_W;

  // Control record that rides alongside the datapath
  typedef struct packed {
    logic                             empty;
    logic                             interp;
    logic [NUM_CHAN-1:0][CHAN_W-1:0]  base;
    logic [NUM_CHAN-1:0]              neg;
  } gcm_ctrl_t;

  // Reset gradient: blue, cyan, green, yellow, red at quarter steps
  function automatic logic [STOP_W-1:0] default_stop(input int idx);
    logic [STOP_W-1:0] word;
    case (idx)
      0:       word = 41'h000_0000_00FF;
      1:       word = 41'h040_0000_FFFF;
      2:       word = 41'h080_0000_FF00;
      3:       word = 41'h0C0_00FF_FF00;
      4:       word = 41'h100_00FF_0000;
      default: word = '0;
    endcase
    return word;
  endfunction

endpackage

### hw/rtl/gcm_div.sv
// ----------------------------------------------------------------------------
// gcm_div: pipelined restoring divider, one quotient bit per stage
// Divides a product by a span where the quotient is known to be below 256.
// Advances only when en is high.
// ----------------------------------------------------------------------------
module gcm_div import gcm_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [PROD_W-1:0] dividend,
  input  logic [POS_W-1:0]  divisor,
  output logic [CHAN_W-1:0] quotient
);

  logic [PROD_W-1:0] rem [0:DIV_STEPS];
  logic [POS_W-1:0]  dvs [0:DIV_STEPS];
  logic [CHAN_W-1:0] quo [0:DIV_STEPS];

  assign rem[0] = dividend;
  assign dvs[0] = divisor;
  assign quo[0] = '0;

  // One trial subtract per stage, most significant quotient bit first
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    localparam int B = DIV_STEPS - 1 - k;
    logic [PROD_W-1:0] trial;
    logic              fits;

    assign trial = PROD_W'(dvs[k]) << B;
    assign fits  = (rem[k] >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= fits ? (rem[k] - trial) : rem[k];
        dvs[k+1] <= dvs[k];
        quo[k+1] <= {quo[k][CHAN_W-2:0], fits};
      end
    end
  end

  assign quotient = quo[DIV_STEPS];

endmodule

### hw/rtl/gradient_color_map_top.sv
// ----------------------------------------------------------------------------
// gradient_color_map_top: Q16 scalar to RGB heatmap color
// Piecewise linear interpolation between up to MAX_STOPS color stops.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / level) takes one Q16 level a beat.
//   Output channel (out_valid / out_stall / red_level, green_level,
//   blue_level, empty_flag) returns one color beat per level, in order.
//   Register port (cfg_en / cfg_addr / cfg_data): index 0 is the stop count,
//   indexes 1..7 are the stop words; write only while the block is idle.
//   The pipeline stages are stop search, span setup, multiply, an 8-stage
//   divider (one quotient bit per stage) and the output register.
//   Throughput is one beat per cycle unless the output stalls; the divider pipeline sets the depth.
//   When out_stall holds a waiting beat, the whole pipeline freezes and
//   in_stall rises in the same cycle; nothing is dropped or repeated.
//   Reset (rst, synchronous) empties the pipeline and loads the five-stop
//   blue-cyan-green-yellow-red gradient with a stop count of five.
// ----------------------------------------------------------------------------
module gradient_color_map_top import gcm_pkg::*; #(
  parameter int MAX_STOPS = 7
) (
  input  logic                  clk,
  input  logic                  rst,
  // register write port
  input  logic                  cfg_en,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [STOP_W-1:0]     cfg_data,
  // input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [POS_W-1:0]      level,
  // output channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [CHAN_W-1:0]     red_level,
  output logic [CHAN_W-1:0]     green_level,
  output logic [CHAN_W-1:0]     blue_level,
  output logic                  empty_flag
);

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  logic [COUNT_W-1:0] stop_count;
  logic [STOP_W-1:0]  stops [MAX_STOPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      stop_count <= STOP_COUNT_RST;
      for (int i = 0; i < MAX_STOPS; i++) begin
        stops[i] <= default_stop(i);
      end
    end else if (cfg_en) begin
      if (cfg_addr == REG_STOP_COUNT) begin
        stop_count <= cfg_data[COUNT_W-1:0];
      end
      for (int i = 0; i < MAX_STOPS; i++) begin
        if (cfg_addr == REG_STOP_BASE + CFG_ADDR_W'(i)) begin
          stops[i] <= cfg_data;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline enable: everything moves unless a finished beat is held
  // --------------------------------------------------------------------------
  logic en;

  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  // --------------------------------------------------------------------------
  // Stage 1: find the first live stop above the level
  // --------------------------------------------------------------------------
  logic [COUNT_W-1:0]   n_eff;
  logic [MAX_STOPS-1:0] live, above, first_hot, last_hot;
  logic                 found;
  logic [STOP_W-1:0]    prev_word, curr_word, base_word;

  assign n_eff = (stop_count > COUNT_W'(MAX_STOPS)) ? COUNT_W'(MAX_STOPS) : stop_count;

  always_comb begin
    logic seen;
    seen = 1'b0;
    for (int i = 0; i < MAX_STOPS; i++) begin
      live[i]      = (COUNT_W'(i) < n_eff);
      above[i]     = live[i] && (level < stops[i][STOP_W-1:POS_LSB]);
      first_hot[i] = above[i] && !seen;
      seen         = seen || above[i];
      last_hot[i]  = live[i] && (COUNT_W'(i + 1) == n_eff);
    end
  end

  assign found = |above;

  // one-hot selection of the bracketing stops
  always_comb begin
    logic [STOP_W-1:0] last_word;
    prev_word = '0;
    curr_word = '0;
    last_word = '0;
    for (int i = 0; i < MAX_STOPS; i++) begin
      if (first_hot[i]) curr_word = curr_word | stops[i];
      if (last_hot[i])  last_word = last_word | stops[i];
    end
    for (int i = 1; i < MAX_STOPS; i++) begin
      if (first_hot[i]) prev_word = prev_word | stops[i-1];
    end
    if (!found) begin
      base_word = last_word;
    end else if (first_hot[0]) begin
      base_word = stops[0];
    end else begin
      base_word = prev_word;
    end
  end

  logic                v1;
  logic                empty1, interp1;
  logic [COLOR_W-1:0]  base1, curr1;
  logic [POS_W-1:0]    lvl1, ppos1, cpos1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      empty1  <= (n_eff == '0);
      interp1 <= found && !first_hot[0];
      base1   <= base_word[COLOR_W-1:0];
      curr1   <= curr_word[COLOR_W-1:0];
      lvl1    <= level;
      ppos1   <= prev_word[STOP_W-1:POS_LSB];
      cpos1   <= curr_word[STOP_W-1:POS_LSB];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: offsets, span and per-channel color step
  // --------------------------------------------------------------------------
  logic                             v2;
  gcm_ctrl_t                        ctrl2;
  logic [POS_W-1:0]                 num2, den2;
  logic [NUM_CHAN-1:0][CHAN_W-1:0]  mag2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctrl2.empty  <= empty1;
      ctrl2.interp <= interp1;
      ctrl2.base   <= base1;
      num2         <= lvl1 - ppos1;
      den2         <= cpos1 - ppos1;
      for (int c = 0; c < NUM_CHAN; c++) begin
        ctrl2.neg[c] <= (curr1[c*CHAN_W +: CHAN_W] < base1[c*CHAN_W +: CHAN_W]);
        mag2[c]      <= (curr1[c*CHAN_W +: CHAN_W] < base1[c*CHAN_W +: CHAN_W])
                      ? (base1[c*CHAN_W +: CHAN_W] - curr1[c*CHAN_W +: CHAN_W])
                      : (curr1[c*CHAN_W +: CHAN_W] - base1[c*CHAN_W +: CHAN_W]);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: step magnitude times offset
  // --------------------------------------------------------------------------
  logic                             v3;
  gcm_ctrl_t                        ctrl3;
  logic [POS_W-1:0]                 den3;
  logic [NUM_CHAN-1:0][PROD_W-1:0]  prod3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctrl3 <= ctrl2;
      den3  <= den2;
      for (int c = 0; c < NUM_CHAN; c++) begin
        prod3[c] <= PROD_W'(mag2[c]) * PROD_W'(num2);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stages 4..11: divide by the span, control record follows alongside
  // --------------------------------------------------------------------------
  logic [NUM_CHAN-1:0][CHAN_W-1:0] quot;

  for (genvar c = 0; c < NUM_CHAN; c++) begin : g_div
    gcm_div u_div (
      .clk      (clk),
      .en       (en),
      .dividend (prod3[c]),
      .divisor  (den3),
      .quotient (quot[c])
    );
  end

  logic      vd    [0:DIV_STEPS];
  gcm_ctrl_t ctrld [0:DIV_STEPS];

  assign vd[0]    = v3;
  assign ctrld[0] = ctrl3;

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_side
    always_ff @(posedge clk) begin
      if (rst) begin
        vd[k+1] <= 1'b0;
      end else if (en) begin
        vd[k+1] <= vd[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ctrld[k+1] <= ctrld[k];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 12: apply the signed step, clamp, output register
  // --------------------------------------------------------------------------
  gcm_ctrl_t                        ctrl_last;
  logic [NUM_CHAN-1:0][SUM_W-1:0]   sum;
  logic [NUM_CHAN-1:0][CHAN_W-1:0]  color;
  logic [NUM_CHAN-1:0]              in_range;

  assign ctrl_last = ctrld[DIV_STEPS];

  always_comb begin
    for (int c = 0; c < NUM_CHAN; c++) begin
      sum[c] = ctrl_last.neg[c]
             ? (SUM_W'(ctrl_last.base[c]) - SUM_W'(quot[c]))
             : (SUM_W'(ctrl_last.base[c]) + SUM_W'(quot[c]));
      in_range[c] = (sum[c][SUM_W-1:CHAN_W] == '0);
      if (ctrl_last.empty) begin
        color[c] = '0;
      end else if (!ctrl_last.interp) begin
        color[c] = ctrl_last.base[c];
      end else if (sum[c][SUM_W-1]) begin
        color[c] = '0;
      end else if (sum[c][CHAN_W]) begin
        color[c] = '1;
      end else begin
        color[c] = sum[c][CHAN_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vd[DIV_STEPS];
    end
  end

  // channel order in the packed color: index 2 red, 1 green, 0 blue
  always_ff @(posedge clk) begin
    if (en) begin
      red_level   <= color[2];
      green_level <= color[1];
      blue_level  <= color[0];
      empty_flag  <= ctrl_last.empty;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // an empty gradient always shows black
  a_empty_black: assert property (@(posedge clk) disable iff (rst)
    out_valid && empty_flag |-> (red_level == '0) && (green_level == '0) &&
                                (blue_level == '0))
    else $error("empty gradient produced a nonzero color");

  // interpolation never leaves the 0..255 channel range before the clamp
  a_interp_range: assert property (@(posedge clk) disable iff (rst)
    vd[DIV_STEPS] && !ctrl_last.empty && ctrl_last.interp |-> (&in_range))
    else $error("interpolated channel out of range before clamp");

  // an output beat only appears from a valid last divider stage
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(vd[DIV_STEPS]))
    else $error("output beat without a source in the pipeline");

endmodule
